[rtl/mse_pkg.sv]
// Shared types and constants of the multistep extrapolator.
// No dependencies; mse_lane, mse_merge, the top level and the testbench take names from here by scope.
`default_nettype none
package mse_pkg;

  localparam int MAX_TAPS_DEF  = 8;
  localparam int MAX_ELEMS_DEF = 1024;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  localparam logic [1:0] SEQ_ZEROTH = 2'd0;
  localparam logic [1:0] SEQ_FIRST  = 2'd1;
  localparam logic [1:0] SEQ_SECOND = 2'd2;
  localparam logic [1:0] SEQ_OUTPUT = 2'd3;

  localparam logic [7:0] REG_NUM_INPUTS = 8'd0;
  localparam logic [7:0] REG_SUM_OUTPUT = 8'd1;
  localparam logic [7:0] REG_TAP_COUNT  = 8'd2;
  localparam logic [7:0] REG_DELTA_TIME = 8'd3;

  localparam int LANES = 4;

  typedef struct packed {
    logic               cmd;
    logic [9:0]         elem_index;
    logic signed [31:0] value_zeroth;
    logic signed [31:0] value_first;
    logic signed [31:0] value_second;
    logic               end_of_step;
    logic [1:0]         coef_seq;
    logic [2:0]         coef_tap;
    logic signed [31:0] coef_value;
  } sample_t;

  typedef struct packed {
    logic [9:0]         elem_index_out;
    logic signed [31:0] result_value;
    logic               step_done;
  } result_t;

  typedef struct packed {
    logic [7:0]  idx;
    logic [31:0] value;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
    logic use_new;
    logic en;
  } lane_ctl_t;

endpackage
`default_nettype wire

[rtl/mse_chan.sv]
// Valid/ready channel carrying one word of type T.
// Depends on nothing; payload types come from mse_pkg at instantiation.
`default_nettype none
interface mse_chan #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/mse_ram.sv]
// Generic one-write one-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mse_ram #(
  parameter int W = 32,
  parameter int D = 1024,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/mse_lane.sv]
// One multiply-accumulate lane: coefficient set, product stage, accumulator.
// Depends on mse_pkg for the lane control word.
`default_nettype none
module mse_lane #(
  parameter int MAX_TAPS = mse_pkg::MAX_TAPS_DEF,
  localparam int KW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1,
  localparam int LW = $clog2(MAX_TAPS + 1),
  localparam int LACC_W = 64 + LW
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire mse_pkg::lane_ctl_t       ctl,
  input  wire logic [KW-1:0]            k,
  input  wire logic signed [31:0]       rdata,
  input  wire logic signed [31:0]       new_value,
  input  wire logic                     coef_we,
  input  wire logic [KW-1:0]            coef_tap,
  input  wire logic signed [31:0]       coef_wdata,
  output logic signed [LACC_W-1:0]      acc,
  output logic                          acc_valid
);
  logic signed [31:0] coef [MAX_TAPS];
  mse_pkg::lane_ctl_t c1, c2;
  logic [KW-1:0]      k1;
  logic signed [31:0] x;
  logic signed [63:0] prod;

  assign x = c1.use_new ? new_value : rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        coef[i] <= '0;
      end
    end else if (coef_we) begin
      coef[coef_tap] <= coef_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1        <= '0;
      c2        <= '0;
      acc_valid <= 1'b0;
    end else begin
      c1        <= ctl;
      c2        <= c1;
      acc_valid <= c2.valid && c2.last;
    end
  end

  always_ff @(posedge clk) begin
    k1 <= k;
    if (c1.en) begin
      prod <= x * coef[k1];
    end else begin
      prod <= '0;
    end
    if (c2.valid) begin
      acc <= (c2.first ? LACC_W'(0) : acc) + LACC_W'(prod);
    end
  end
endmodule
`default_nettype wire

[rtl/mse_merge.sv]
// Merging stage: adds the lane sums, rounds to Q16.16 and saturates.
// Depends on mse_pkg for the lane count.
`default_nettype none
module mse_merge #(
  parameter int LACC_W = 68,
  localparam int MACC_W = LACC_W + 2,
  localparam int RW = MACC_W - 24
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic signed [LACC_W-1:0] acc [mse_pkg::LANES],
  input  wire logic                    acc_valid,
  output logic signed [31:0]           y,
  output logic                         y_valid
);
  localparam logic signed [RW-1:0] YMAX = RW'(32'sh7fffffff);
  localparam logic signed [RW-1:0] YMIN = RW'($signed(32'h80000000));

  logic signed [MACC_W-1:0] sum, rnd;
  logic signed [RW-1:0]     r;
  logic                     sum_valid;

  assign rnd = sum + MACC_W'(25'sd8388608);
  assign r   = $signed(rnd[MACC_W-1:24]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
      y_valid   <= 1'b0;
    end else begin
      sum_valid <= acc_valid;
      y_valid   <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    sum <= MACC_W'(acc[0]) + MACC_W'(acc[1]) + MACC_W'(acc[2]) + MACC_W'(acc[3]);
    if (r > YMAX) begin
      y <= 32'sh7fffffff;
    end else if (r < YMIN) begin
      y <= $signed(32'h80000000);
    end else begin
      y <= 32'(r);
    end
  end
endmodule
`default_nettype wire

[rtl/multistep_extrapolator_unit.sv]
// Top level of the multistep extrapolator: control, history RAMs, lanes, merge.
// Depends on mse_pkg, mse_chan, mse_ram, mse_lane and mse_merge.
//
//   channel  dir  word      accepted when
//   sample   in   sample_t  sample.valid && sample.ready
//   result   out  result_t  result.valid && result.ready
//   cfg      in   cfg_t     cfg.valid && cfg.ready (ready always high)
//
// A sample passes through accept, an issue step for each tap, product, sum, round and
// write-back; the four lanes run one history RAM read each per cycle.
// Write-back holds while the output register is full and not taken.
// A coefficient write passes through S_MUL and S_RND once per delta_time scaling step.
// After reset a clearing pass over all MAX_TAPS*MAX_ELEMS addresses zeroes the
// histories; sample.ready stays low meanwhile, configuration is taken.
// The next sample is taken while a finished result waits in the output register.
`default_nettype none
module multistep_extrapolator_unit #(
  parameter int MAX_TAPS  = mse_pkg::MAX_TAPS_DEF,
  parameter int MAX_ELEMS = mse_pkg::MAX_ELEMS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  mse_chan.sink     sample,
  mse_chan.source   result,
  mse_chan.sink     cfg
);
  localparam int KW     = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int LW     = $clog2(MAX_TAPS + 1);
  localparam int EW     = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
  localparam int DEPTH  = MAX_TAPS * MAX_ELEMS;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LACC_W = 64 + LW;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_RUN   = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_WRITE = 7'b0010000,
    S_MUL   = 7'b0100000,
    S_RND   = 7'b1000000
  } state_t;

  state_t state;

  logic [1:0]  num_inputs;
  logic        sum_output;
  logic [3:0]  tap_count;
  logic [31:0] delta_time;

  mse_pkg::sample_t it;
  mse_pkg::result_t ob;
  logic             ob_valid;
  logic [KW-1:0]    head, k;
  logic [AW-1:0]    clr_addr;
  logic signed [31:0] y_pend;

  logic signed [31:0] c;
  logic signed [64:0] sp, spr;
  logic signed [40:0] sh;
  logic signed [31:0] c_next;
  logic [1:0]         ord_left;

  logic [LW-1:0] taps, hx, kx, slot_in_w, slot_out_w;
  logic [KW-1:0] slot_in, slot_out, head_next;
  logic [1:0]    n_in;
  logic [EW-1:0] e;
  logic [AW-1:0] addr_in, addr_out, addr_head;
  logic          last, in_fire, out_fire, wr_go, sample_ok, tap_ok, head_adv;
  logic [1:0]    ord_in;

  logic          cw_we;
  logic [1:0]    cw_seq;
  logic [KW-1:0] cw_tap;
  logic signed [31:0] cw_val;

  logic               lane_en  [mse_pkg::LANES];
  logic signed [31:0] newv     [mse_pkg::LANES];
  logic signed [31:0] rd       [mse_pkg::LANES];
  logic               ram_we   [mse_pkg::LANES];
  logic [AW-1:0]      ram_wa   [mse_pkg::LANES];
  logic [AW-1:0]      ram_ra   [mse_pkg::LANES];
  logic signed [31:0] ram_wd   [mse_pkg::LANES];
  logic signed [LACC_W-1:0] acc [mse_pkg::LANES];
  logic               acc_v    [mse_pkg::LANES];
  mse_pkg::lane_ctl_t ctl      [mse_pkg::LANES];
  logic signed [31:0] y;
  logic               y_valid;

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign result.valid = ob_valid;
  assign result.data  = ob;
  assign in_fire      = sample.valid && sample.ready;
  assign out_fire     = result.valid && result.ready;
  assign wr_go        = (state == S_WRITE) && (!ob_valid || result.ready);
  assign head_adv     = (in_fire && sample.data.cmd == mse_pkg::CMD_SAMPLE && !sample_ok
                         && sample.data.end_of_step) || (wr_go && it.end_of_step);

  always_comb begin
    if (tap_count == 4'd0) begin
      taps = LW'(1);
    end else if (32'(tap_count) > MAX_TAPS) begin
      taps = LW'(MAX_TAPS);
    end else begin
      taps = LW'(tap_count);
    end
  end

  assign n_in       = (num_inputs == 2'd0) ? 2'd1 : num_inputs;
  assign hx         = LW'(head);
  assign kx         = LW'(k);
  assign slot_in_w  = (hx >= kx) ? hx - kx : hx + taps - kx;
  assign slot_out_w = (hx > kx) ? hx - kx - LW'(1) : hx + taps - kx - LW'(1);
  assign slot_in    = KW'(slot_in_w);
  assign slot_out   = KW'(slot_out_w);
  assign last       = (kx == taps - LW'(1));
  assign head_next  = (hx + LW'(1) >= taps) ? '0 : head + KW'(1);
  assign e          = EW'(it.elem_index);
  assign addr_in    = AW'(slot_in) * AW'(MAX_ELEMS) + AW'(e);
  assign addr_out   = AW'(slot_out) * AW'(MAX_ELEMS) + AW'(e);
  assign addr_head  = AW'(head) * AW'(MAX_ELEMS) + AW'(e);
  assign sample_ok  = 32'(sample.data.elem_index) < MAX_ELEMS;
  assign tap_ok     = 32'(sample.data.coef_tap) < MAX_TAPS;
  assign ord_in     = (sample.data.coef_seq == mse_pkg::SEQ_OUTPUT) ? 2'd0
                                                                    : sample.data.coef_seq;

  assign spr = sp + 65'sd8388608;
  assign sh  = $signed(spr[64:24]);
  always_comb begin
    if (sh > 41'sd2147483647) begin
      c_next = 32'sh7fffffff;
    end else if (sh < -41'sd2147483648) begin
      c_next = $signed(32'h80000000);
    end else begin
      c_next = 32'(sh);
    end
  end

  always_comb begin
    cw_we  = 1'b0;
    cw_seq = it.coef_seq;
    cw_tap = KW'(it.coef_tap);
    cw_val = c_next;
    if (state == S_IDLE && in_fire && sample.data.cmd == mse_pkg::CMD_COEF && tap_ok
        && ord_in == 2'd0) begin
      cw_we  = 1'b1;
      cw_seq = sample.data.coef_seq;
      cw_tap = KW'(sample.data.coef_tap);
      cw_val = sample.data.coef_value;
    end else if (state == S_RND && ord_left == 2'd1) begin
      cw_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_inputs <= 2'd1;
      sum_output <= 1'b0;
      tap_count  <= 4'd1;
      delta_time <= 32'd16777216;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.data.idx)
        mse_pkg::REG_NUM_INPUTS: num_inputs <= cfg.data.value[1:0];
        mse_pkg::REG_SUM_OUTPUT: sum_output <= cfg.data.value[0];
        mse_pkg::REG_TAP_COUNT:  tap_count  <= cfg.data.value[3:0];
        mse_pkg::REG_DELTA_TIME: delta_time <= cfg.data.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      head     <= '0;
      k        <= '0;
      clr_addr <= '0;
      ob_valid <= 1'b0;
      ord_left <= 2'd0;
    end else begin
      if (wr_go) begin
        ob_valid <= 1'b1;
      end else if (out_fire) begin
        ob_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (sample.data.cmd == mse_pkg::CMD_COEF) begin
              if (tap_ok && ord_in != 2'd0) begin
                ord_left <= ord_in;
                state    <= S_MUL;
              end
            end else if (sample_ok) begin
              k     <= '0;
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          k <= k + KW'(1);
          if (last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (y_valid) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (wr_go) begin
            state <= S_IDLE;
          end
        end
        S_MUL: begin
          state <= S_RND;
        end
        S_RND: begin
          ord_left <= ord_left - 2'd1;
          state    <= (ord_left == 2'd1) ? S_IDLE : S_MUL;
        end
        default: state <= S_IDLE;
      endcase
      if (cfg.valid && cfg.ready && cfg.data.idx == mse_pkg::REG_TAP_COUNT) begin
        head <= '0;
      end else if (head_adv) begin
        head <= head_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      it <= sample.data;
    end
    if (state == S_IDLE) begin
      c <= sample.data.coef_value;
    end else if (state == S_RND) begin
      c <= c_next;
    end
    sp <= c * $signed({1'b0, delta_time});
    if (state == S_DRAIN && y_valid) begin
      y_pend <= y;
    end
    if (wr_go) begin
      ob.elem_index_out <= it.elem_index;
      ob.result_value   <= y_pend;
      ob.step_done      <= it.end_of_step;
    end
  end

  assign lane_en[0] = 1'b1;
  assign lane_en[1] = (n_in >= 2'd2);
  assign lane_en[2] = (n_in == 2'd3);
  assign lane_en[3] = sum_output;
  assign newv[0]    = it.value_zeroth;
  assign newv[1]    = it.value_first;
  assign newv[2]    = it.value_second;
  assign newv[3]    = y_pend;

  for (genvar s = 0; s < mse_pkg::LANES; s++) begin : g_lane
    always_comb begin
      ctl[s].valid   = (state == S_RUN);
      ctl[s].first   = (k == '0);
      ctl[s].last    = last;
      ctl[s].use_new = (s != mse_pkg::LANES - 1) && (k == '0);
      ctl[s].en      = lane_en[s];
      ram_ra[s]      = (s == mse_pkg::LANES - 1) ? addr_out : addr_in;
      if (state == S_CLEAR) begin
        ram_we[s] = 1'b1;
        ram_wa[s] = clr_addr;
        ram_wd[s] = '0;
      end else begin
        ram_wa[s] = addr_head;
        ram_wd[s] = newv[s];
        if (s == mse_pkg::LANES - 1) begin
          ram_we[s] = wr_go && sum_output;
        end else begin
          ram_we[s] = (state == S_RUN) && (k == '0) && lane_en[s];
        end
      end
    end

    mse_ram #(.W(32), .D(DEPTH)) u_hist (
      .clk   (clk),
      .we    (ram_we[s]),
      .waddr (ram_wa[s]),
      .wdata (ram_wd[s]),
      .raddr (ram_ra[s]),
      .rdata (rd[s])
    );

    mse_lane #(.MAX_TAPS(MAX_TAPS)) u_lane (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl[s]),
      .k          (k),
      .rdata      (rd[s]),
      .new_value  (newv[s]),
      .coef_we    (cw_we && (cw_seq == 2'(s))),
      .coef_tap   (cw_tap),
      .coef_wdata (cw_val),
      .acc        (acc[s]),
      .acc_valid  (acc_v[s])
    );
  end

  mse_merge #(.LACC_W(LACC_W)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .acc       (acc),
    .acc_valid (acc_v[0] & acc_v[1] & acc_v[2] & acc_v[3]),
    .y         (y),
    .y_valid   (y_valid)
  );
endmodule
`default_nettype wire

[tb/tb_multistep_extrapolator_unit.sv]
// Testbench of multistep_extrapolator_unit: directed and random sample and coefficient words,
// checked against a behavioral predictor of the fixed-point extrapolation.
// Depends on mse_pkg, mse_chan and the RTL of the block.
`default_nettype none
module tb_multistep_extrapolator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NT = mse_pkg::MAX_TAPS_DEF;
  localparam int NE = mse_pkg::MAX_ELEMS_DEF;
  localparam int WATCH_LIMIT = 50000;
  localparam int SETTLE = 40;

  logic clk;
  logic rst;

  mse_chan #(.T(mse_pkg::sample_t)) smp ();
  mse_chan #(.T(mse_pkg::result_t)) res ();
  mse_chan #(.T(mse_pkg::cfg_t))    cfg ();

  multistep_extrapolator_unit u_dut (
    .clk(clk), .rst(rst), .sample(smp), .result(res), .cfg(cfg)
  );

  // predictor state
  logic [1:0]  p_inputs;
  logic        p_recur;
  logic [3:0]  p_taps;
  logic [31:0] p_dt;
  int unsigned p_head;
  int          hist_in[3][NT*NE];
  int          hist_out[NT*NE];
  int          coef_mem[4*NT];

  mse_pkg::result_t pending_results[$];
  int      mismatches;
  bit      idle_on;
  int      quiet_cycles;
  int      stall_left;

  function automatic int sat32(longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return int'(v);
  endfunction

  function automatic int scale_dt(int c, logic [31:0] dt);
    longint p;
    p = longint'(c) * longint'({32'd0, dt});
    return sat32((p + 64'sd8388608) >>> 24);
  endfunction

  task automatic track_word(mse_pkg::sample_t w);
    int unsigned l, head, n, slot, e;
    int c;
    int unsigned ord;
    longint hi, lo, p, h;
    mse_pkg::result_t r;
    l = (p_taps < 1) ? 1 : (p_taps > NT) ? NT : p_taps;
    head = (p_head < l) ? p_head : 0;
    n = (p_inputs == 0) ? 1 : p_inputs;
    if (w.cmd == mse_pkg::CMD_COEF) begin
      c = int'(w.coef_value);
      ord = (w.coef_seq < mse_pkg::SEQ_OUTPUT) ? w.coef_seq : 0;
      for (int i = 0; i < ord; i++) c = scale_dt(c, p_dt);
      coef_mem[w.coef_seq*NT + w.coef_tap] = c;
      return;
    end
    e = w.elem_index;
    hi = 0;
    lo = 0;
    for (int s = 0; s < n; s++) begin
      hist_in[s][head*NE + e] = (s == 0) ? int'(w.value_zeroth) :
                                (s == 1) ? int'(w.value_first) : int'(w.value_second);
      for (int k = 0; k < l; k++) begin
        slot = (head + l - k) % l;
        p = longint'(hist_in[s][slot*NE + e]) * longint'(coef_mem[s*NT + k]);
        h = p >>> 24;
        hi += h;
        lo += p - (h <<< 24);
      end
    end
    if (p_recur) begin
      for (int k = 0; k < l; k++) begin
        slot = (head + 2*l - 1 - k) % l;
        p = longint'(hist_out[slot*NE + e]) * longint'(coef_mem[3*NT + k]);
        h = p >>> 24;
        hi += h;
        lo += p - (h <<< 24);
      end
    end
    r.elem_index_out = w.elem_index;
    r.result_value = sat32(hi + ((lo + 64'sd8388608) >>> 24));
    r.step_done = w.end_of_step;
    if (p_recur) hist_out[head*NE + e] = r.result_value;
    pending_results.push_back(r);
    if (w.end_of_step) p_head = (head + 1 >= l) ? 0 : head + 1;
  endtask

  function automatic mse_pkg::sample_t mk_sample(int e, int z, int f, int s, bit eos);
    mse_pkg::sample_t w;
    w.cmd = mse_pkg::CMD_SAMPLE;
    w.elem_index = e[9:0];
    w.value_zeroth = z;
    w.value_first = f;
    w.value_second = s;
    w.end_of_step = eos;
    w.coef_seq = 2'($urandom);
    w.coef_tap = 3'($urandom);
    w.coef_value = $urandom;
    return w;
  endfunction

  function automatic mse_pkg::sample_t mk_coef(logic [1:0] seq, int tap, int v);
    mse_pkg::sample_t w;
    w.cmd = mse_pkg::CMD_COEF;
    w.elem_index = 10'($urandom);
    w.value_zeroth = $urandom;
    w.value_first = $urandom;
    w.value_second = $urandom;
    w.end_of_step = 1'($urandom);
    w.coef_seq = seq;
    w.coef_tap = tap[2:0];
    w.coef_value = v;
    return w;
  endfunction

  task automatic send_word(mse_pkg::sample_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    smp.valid <= 1'b1;
    smp.data <= w;
    do @(posedge clk); while (!smp.ready);
    track_word(w);
    @(negedge clk);
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] v);
    cfg.valid <= 1'b1;
    cfg.data <= '{idx: idx, value: v};
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      mse_pkg::REG_NUM_INPUTS: p_inputs = v[1:0];
      mse_pkg::REG_SUM_OUTPUT: p_recur = v[0];
      mse_pkg::REG_TAP_COUNT: begin
        p_taps = v[3:0];
        p_head = 0;
      end
      mse_pkg::REG_DELTA_TIME: p_dt = v;
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_mode(int ni, int so, int tc, logic [31:0] dt);
    drain();
    write_reg(mse_pkg::REG_NUM_INPUTS, ni);
    write_reg(mse_pkg::REG_SUM_OUTPUT, so);
    write_reg(mse_pkg::REG_TAP_COUNT, tc);
    write_reg(mse_pkg::REG_DELTA_TIME, dt);
  endtask

  function automatic int rand_data();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
  endfunction

  function automatic int rand_coef();
    if ($urandom_range(0, 5) == 0) return $urandom;
    return int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
  endfunction

  task automatic test_directed();
    set_mode(3, 1, 4, 32'h0100_0000);
    send_word(mk_coef(mse_pkg::SEQ_ZEROTH, 0, 32'h7fffffff));
    send_word(mk_coef(mse_pkg::SEQ_FIRST, 1, 32'h80000000));
    send_word(mk_coef(mse_pkg::SEQ_SECOND, 0, 32'h0100_0000));
    send_word(mk_coef(mse_pkg::SEQ_OUTPUT, 0, 32'h0080_0000));
    send_word(mk_coef(mse_pkg::SEQ_ZEROTH, 7, 32'h0000_1000));
    send_word(mk_sample(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0));
    send_word(mk_sample(1023, 32'h80000000, 32'h80000000, 32'h80000000, 1'b1));
    send_word(mk_sample(0, 32'h0001_0000, 32'hffff_0000, 0, 1'b1));
    send_word(mk_sample(1023, 0, 0, 0, 1'b1));
    drain();
    write_reg(mse_pkg::REG_DELTA_TIME, 32'h0);
    send_word(mk_coef(mse_pkg::SEQ_FIRST, 2, 32'h7fffffff));
    drain();
    write_reg(mse_pkg::REG_DELTA_TIME, 32'hffffffff);
    send_word(mk_coef(mse_pkg::SEQ_SECOND, 3, 32'h7fffffff));
    send_word(mk_coef(mse_pkg::SEQ_OUTPUT, 1, 32'h80000000));
    drain();
    write_reg(mse_pkg::REG_DELTA_TIME, 32'h0100_0000);
    send_word(mk_sample(5, 32'h0002_0000, 32'h0001_0000, 32'h0000_8000, 1'b1));
    send_word(mk_sample(5, 32'h0003_0000, 32'h0001_0000, 32'h0000_8000, 1'b1));
    set_mode(0, 0, 0, 32'h0100_0000);
    write_reg(8'd4, 32'hffffffff);
    write_reg(8'hff, 32'h0);
    send_word(mk_sample(2, 32'h0001_0000, 0, 0, 1'b1));
    set_mode(3, 1, 15, 32'h0080_0000);
    send_word(mk_sample(2, 32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 1'b1));
    send_word(mk_sample(3, 32'h8000_0001, 32'h7fff_ffff, 32'h1234_5678, 1'b0));
  endtask

  task automatic test_random(int count);
    int elems;
    int pos;
    elems = $urandom_range(1, 6);
    pos = 0;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_word(mk_coef(2'($urandom), $urandom_range(0, 7), rand_coef()));
      end else if ($urandom_range(0, 19) == 0) begin
        send_word(mk_sample($urandom_range(0, 1023), rand_data(), rand_data(), rand_data(),
                            1'($urandom_range(0, 1))));
      end else begin
        send_word(mk_sample(pos, rand_data(), rand_data(), rand_data(), pos == elems - 1));
        pos = (pos == elems - 1) ? 0 : pos + 1;
      end
    end
  endtask

  task automatic test_modes();
    set_mode(1, 0, 1, 32'h0100_0000);
    test_random(200);
    set_mode(3, 1, 8, 32'hffffffff);
    test_random(200);
    set_mode(2, 1, 3, 32'h0080_0000);
    test_random(200);
    drain();
    smp.valid <= 1'b0;
    set_mode(3, 0, 15, 32'h0);
    test_random(200);
    set_mode(2, 1, 5, $urandom);
    test_random(200);
    set_mode(0, 1, 0, 32'h0180_0000);
    test_random(150);
  endtask

  task automatic test_no_idle();
    set_mode(3, 1, 6, 32'h0100_0000);
    idle_on = 1'b0;
    test_random(180);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 6);
    res.ready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    mse_pkg::result_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", res.data);
      end else begin
        want = pending_results.pop_front();
        if (res.data.elem_index_out !== want.elem_index_out ||
            res.data.result_value !== want.result_value ||
            res.data.step_done !== want.step_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result mismatch: expected elem %0d value %0d done %0b,",
                      " got elem %0d value %0d done %0b"},
                     want.elem_index_out, want.result_value, want.step_done,
                     res.data.elem_index_out, res.data.result_value, res.data.step_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
      quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCH_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    idle_on = 1'b1;
    mismatches = 0;
    quiet_cycles = 0;
    stall_left = 0;
    smp.valid = 1'b0;
    smp.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    res.ready = 1'b0;
    p_inputs = 2'd1;
    p_recur = 1'b0;
    p_taps = 4'd1;
    p_dt = 32'h0100_0000;
    p_head = 0;
    foreach (hist_out[i]) hist_out[i] = 0;
    foreach (hist_in[s, i]) hist_in[s][i] = 0;
    foreach (coef_mem[i]) coef_mem[i] = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_modes();
    test_no_idle();
    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
`default_nettype wire

[multistep_extrapolator_unit.f]
rtl/mse_pkg.sv
rtl/mse_chan.sv
rtl/mse_ram.sv
rtl/mse_lane.sv
rtl/mse_merge.sv
rtl/multistep_extrapolator_unit.sv
tb/tb_multistep_extrapolator_unit.sv
